@@ rtl/core/sfe_pkg.sv @@
// Shared types and constants for the framed Fletcher-8 encoder.
`default_nettype none

package sfe_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int STEP_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_BYTE,
        KIND_BYTE_LAST,
        KIND_STRAY
    } kind_t;

    // One queued job: b0 carries the class byte or the payload byte.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

`default_nettype wire

@@ rtl/core/sfe_front.sv @@
// Front end: accepts input words, tracks the open frame and queues jobs.
`default_nettype none

module sfe_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     operation,
    input  wire logic [sfe_pkg::BYTE_W-1:0] class_id,
    input  wire logic [sfe_pkg::BYTE_W-1:0] message_id,
    input  wire logic [sfe_pkg::LEN_W-1:0]  payload_length,
    input  wire logic [sfe_pkg::BYTE_W-1:0] payload_byte,
    input  wire logic                     q_full,
    output logic                          q_push,
    output sfe_pkg::cmd_t                 q_cmd
);
    import sfe_pkg::*;

    logic              frame_open_reg, frame_open_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]  left_dec;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign left_dec = bytes_left_reg - LEN_W'(1);

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        q_cmd.b0  = payload_byte;
        q_cmd.b1  = message_id;
        q_cmd.len = payload_length;
        if (operation == OP_START)
        begin
            q_cmd.kind = KIND_START;
            q_cmd.b0   = class_id;
            if (q_push)
            begin
                // A zero-length frame closes inside its own header job.
                frame_open_next = (payload_length != '0);
                bytes_left_next = payload_length;
            end
        end
        else if (!frame_open_reg)
        begin
            q_cmd.kind = KIND_STRAY;
        end
        else
        begin
            q_cmd.kind = (left_dec == '0) ? KIND_BYTE_LAST : KIND_BYTE;
            if (q_push)
            begin
                bytes_left_next = left_dec;
                frame_open_next = (left_dec != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sfe_queue.sv @@
// Short job queue between the front end and the byte sequencer.
`default_nettype none

module sfe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire sfe_pkg::cmd_t push_cmd,
    output logic             full,
    input  wire logic        pop,
    output sfe_pkg::q_head_t head
);
    import sfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sfe_back.sv @@
// Back end: steps through each job, keeps the Fletcher sums, drives the output word.
`default_nettype none

module sfe_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sfe_pkg::q_head_t           head,
    output logic                            pop,
    input  wire logic [sfe_pkg::BYTE_W-1:0] sync_first,
    input  wire logic [sfe_pkg::BYTE_W-1:0] sync_second,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [sfe_pkg::BYTE_W-1:0]      out_byte,
    output logic                            last_of_run,
    output logic                            frame_done,
    output logic                            stray_error
);
    import sfe_pkg::*;

    localparam logic [STEP_W-1:0] STEP_SYNC1  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SYNC2  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CLASS  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MSGID  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LEN_LO = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LEN_HI = 3'd5;
    localparam logic [STEP_W-1:0] STEP_SUM_A  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_SUM_B  = 3'd7;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              last_reg, last_next;
    logic              done_reg, done_next;
    logic              stray_reg, stray_next;

    logic              advance, fire;
    logic [STEP_W-1:0] phase;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_sum, emit_last, emit_done, emit_stray, clear_sums;
    logic [BYTE_W-1:0] add_a;

    assign advance = !out_valid_reg || !out_stall;
    assign fire    = advance && head.valid;

    // The last payload job reuses the header's trailer steps after its data byte.
    always_comb
    begin
        phase = step_reg;
        if (head.cmd.kind == KIND_BYTE_LAST && step_reg != STEP_SYNC1)
        begin
            phase = step_reg + STEP_SUM_A - STEP_SYNC2;
        end
    end

    always_comb
    begin
        emit_byte  = '0;
        emit_sum   = 1'b0;
        emit_last  = 1'b0;
        emit_done  = 1'b0;
        emit_stray = 1'b0;
        clear_sums = 1'b0;
        case (head.cmd.kind)
            KIND_STRAY:
            begin
                emit_stray = 1'b1;
                emit_last  = 1'b1;
            end
            KIND_BYTE:
            begin
                emit_byte = head.cmd.b0;
                emit_sum  = 1'b1;
                emit_last = 1'b1;
            end
            default:
            begin
                case (phase)
                    STEP_SYNC1:
                    begin
                        if (head.cmd.kind == KIND_START)
                        begin
                            emit_byte  = sync_first;
                            clear_sums = 1'b1;
                        end
                        else
                        begin
                            emit_byte = head.cmd.b0;
                            emit_sum  = 1'b1;
                        end
                    end
                    STEP_SYNC2:  emit_byte = sync_second;
                    STEP_CLASS:
                    begin
                        emit_byte = head.cmd.b0;
                        emit_sum  = 1'b1;
                    end
                    STEP_MSGID:
                    begin
                        emit_byte = head.cmd.b1;
                        emit_sum  = 1'b1;
                    end
                    STEP_LEN_LO:
                    begin
                        emit_byte = head.cmd.len[BYTE_W-1:0];
                        emit_sum  = 1'b1;
                    end
                    STEP_LEN_HI:
                    begin
                        emit_byte = head.cmd.len[LEN_W-1:BYTE_W];
                        emit_sum  = 1'b1;
                        emit_last = (head.cmd.len != '0);
                    end
                    STEP_SUM_A:  emit_byte = sum_a_reg;
                    STEP_SUM_B:
                    begin
                        emit_byte = sum_b_reg;
                        emit_last = 1'b1;
                        emit_done = 1'b1;
                    end
                    default:     emit_byte = '0;
                endcase
            end
        endcase
    end

    assign add_a = sum_a_reg + emit_byte;
    assign pop   = fire && emit_last;

    always_comb
    begin
        step_next      = step_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        stray_next     = stray_reg;
        if (advance)
        begin
            out_valid_next = head.valid;
        end
        if (fire)
        begin
            out_byte_next = emit_byte;
            last_next     = emit_last;
            done_next     = emit_done;
            stray_next    = emit_stray;
            step_next     = emit_last ? STEP_SYNC1 : step_reg + STEP_W'(1);
            if (clear_sums)
            begin
                sum_a_next = '0;
                sum_b_next = '0;
            end
            else if (emit_sum)
            begin
                sum_a_next = add_a;
                sum_b_next = sum_b_reg + add_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_SYNC1;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
        stray_reg    <= stray_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign frame_done  = done_reg;
    assign stray_error = stray_reg;

endmodule

`default_nettype wire

@@ rtl/core/sync_frame_fletcher8_encoder_core.sv @@
// Top level of the framed message encoder with Fletcher-8 trailer.
//
//  channel | direction | handshake              | words
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_stall    | op, class_id, message_id, length, byte
//  out     | output    | out_valid / out_stall  | out_byte, last_of_run, frame_done, stray
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The output runs at one word per cycle while out_stall is low. A start word yields 6
// output words (8 for an empty payload), a payload word 1 (3 when it ends the frame), a
// stray word 1; the byte sequencer in the back end sets this. Input words are taken while
// the job queue (QUEUE_DEPTH entries) has room, so payload words pass one per cycle.
// Reset clears the frame state, the queue, the sums and the output valid flag and loads
// the default sync bytes. An output stall holds the output word and backs up the queue.
`default_nettype none

module sync_frame_fletcher8_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [sfe_pkg::BYTE_W-1:0]    class_id,
    input  wire logic [sfe_pkg::BYTE_W-1:0]    message_id,
    input  wire logic [sfe_pkg::LEN_W-1:0]     payload_length,
    input  wire logic [sfe_pkg::BYTE_W-1:0]    payload_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sfe_pkg::BYTE_W-1:0]         out_byte,
    output logic                               last_of_run,
    output logic                               frame_done,
    output logic                               stray_error,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfe_pkg::BYTE_W-1:0]    cfg_data
);
    import sfe_pkg::*;

    logic [BYTE_W-1:0] sync_first_reg, sync_first_next;
    logic [BYTE_W-1:0] sync_second_reg, sync_second_next;
    logic              q_full, q_push, q_pop;
    cmd_t              q_cmd;
    q_head_t           q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sync_first_next  = sync_first_reg;
        sync_second_next = sync_second_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_next  = cfg_data;
                CFG_SYNC_SECOND: sync_second_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else
        begin
            sync_first_reg  <= sync_first_next;
            sync_second_reg <= sync_second_next;
        end
    end

    sfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .class_id       (class_id),
        .message_id     (message_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_cmd)
    );

    sfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    sfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .pop         (q_pop),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_done  (frame_done),
        .stray_error (stray_error)
    );

    // A dropped payload word reports alone, with a zero byte, and never ends a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stray_error |-> last_of_run && !frame_done && (out_byte == '0))
        else $error("stray word carries wrong flags");

    // The second checksum byte always closes the run of its input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run && !stray_error)
        else $error("frame end not marked as end of run");

    // A word is only pushed when the queue can hold it.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into a full queue");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the framed Fletcher-8 message encoder core.
`default_nettype none

typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       stray;
} frame_word_t;

class fletcher_frame_scoreboard;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [15:0] bytes_left;
    logic        frame_open;
    frame_word_t expected_q[$];
    frame_word_t burst_q[$];
    int          errors;
    int          words_checked;
    int          starts_seen;
    int          strays_seen;

    function new();
        sync_first    = sfe_pkg::SYNC_FIRST_RST;
        sync_second   = sfe_pkg::SYNC_SECOND_RST;
        sum_a         = 8'd0;
        sum_b         = 8'd0;
        bytes_left    = 16'd0;
        frame_open    = 1'b0;
        errors        = 0;
        words_checked = 0;
        starts_seen   = 0;
        strays_seen   = 0;
    endfunction

    // Writes to an index outside the register map leave the sync bytes alone.
    function void write_reg(logic [7:0] index, logic [7:0] value);
        if (index == sfe_pkg::CFG_SYNC_FIRST)
            sync_first = value;
        else if (index == sfe_pkg::CFG_SYNC_SECOND)
            sync_second = value;
    endfunction

    function void emit(logic [7:0] data, logic done, logic stray);
        frame_word_t w;
        w.data  = data;
        w.last  = 1'b0;
        w.done  = done;
        w.stray = stray;
        burst_q.push_back(w);
    endfunction

    function void emit_summed(logic [7:0] data);
        sum_a = sum_a + data;
        sum_b = sum_b + sum_a;
        emit(data, 1'b0, 1'b0);
    endfunction

    function void emit_checksum();
        emit(sum_a, 1'b0, 1'b0);
        emit(sum_b, 1'b1, 1'b0);
        frame_open = 1'b0;
    endfunction

    // Works out every output word that one accepted input word causes.
    function void note_input(logic op, logic [7:0] cls, logic [7:0] mid,
                             logic [15:0] len, logic [7:0] pb);
        frame_word_t w;
        burst_q.delete();
        if (op == sfe_pkg::OP_START) begin
            starts_seen++;
            sum_a      = 8'd0;
            sum_b      = 8'd0;
            bytes_left = len;
            frame_open = 1'b1;
            emit(sync_first, 1'b0, 1'b0);
            emit(sync_second, 1'b0, 1'b0);
            emit_summed(cls);
            emit_summed(mid);
            emit_summed(len[7:0]);
            emit_summed(len[15:8]);
            if (len == 16'd0)
                emit_checksum();
        end
        else if (!frame_open) begin
            strays_seen++;
            emit(8'h00, 1'b0, 1'b1);
        end
        else begin
            emit_summed(pb);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
                emit_checksum();
        end
        while (burst_q.size() != 0) begin
            w = burst_q.pop_front();
            w.last = (burst_q.size() == 0);
            expected_q.push_back(w);
        end
    endfunction

    function void flag(string msg);
        if (errors < 10)
            $display("MISMATCH: %s", msg);
        errors++;
    endfunction

    function void check_output(logic [7:0] data, logic last, logic done, logic stray);
        frame_word_t w;
        words_checked++;
        if (expected_q.size() == 0) begin
            flag($sformatf("unexpected output word %0d: byte %02h last %0b done %0b stray %0b",
                           words_checked, data, last, done, stray));
            return;
        end
        w = expected_q.pop_front();
        if (data !== w.data)
            flag($sformatf("word %0d out_byte: expected %02h, got %02h",
                           words_checked, w.data, data));
        if (last !== w.last)
            flag($sformatf("word %0d last_of_run: expected %0b, got %0b",
                           words_checked, w.last, last));
        if (done !== w.done)
            flag($sformatf("word %0d frame_done: expected %0b, got %0b",
                           words_checked, w.done, done));
        if (stray !== w.stray)
            flag($sformatf("word %0d stray_error: expected %0b, got %0b",
                           words_checked, w.stray, stray));
    endfunction
endclass

module tb;
    import sfe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BEYOND = 8'hFF;
    localparam int WORDS_PER_PHASE = 105;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 operation      = OP_START;
    logic [BYTE_W-1:0]    class_id       = '0;
    logic [BYTE_W-1:0]    message_id     = '0;
    logic [LEN_W-1:0]     payload_length = '0;
    logic [BYTE_W-1:0]    payload_byte   = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last_of_run;
    logic                 frame_done;
    logic                 stray_error;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [BYTE_W-1:0]    cfg_data       = '0;

    logic calm = 1'b0;
    int   words_sent = 0;

    fletcher_frame_scoreboard frames = new();

    always #2 clk = ~clk;

    sync_frame_fletcher8_encoder_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .class_id       (class_id),
        .message_id     (message_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .frame_done     (frame_done),
        .stray_error    (stray_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 31);

    // Both channels are sampled here at the edge, before any update lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                frames.note_input(operation, class_id, message_id, payload_length,
                                  payload_byte);
            if (out_valid && !out_stall)
                frames.check_output(out_byte, last_of_run, frame_done, stray_error);
        end
    end

    task automatic send_word(logic op, logic [7:0] cls, logic [7:0] mid,
                             logic [15:0] len, logic [7:0] pb);
        if (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 31);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        class_id       <= cls;
        message_id     <= mid;
        payload_length <= len;
        payload_byte   <= pb;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic send_start(logic [7:0] cls, logic [7:0] mid, logic [15:0] len);
        send_word(OP_START, cls, mid, len, 8'($urandom));
    endtask

    task automatic send_payload(logic [7:0] pb);
        send_word(OP_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom), pb);
    endtask

    task automatic write_reg(logic [7:0] index, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        frames.write_reg(index, value);
    endtask

    // Every input word yields output, so an empty expectation queue means idle.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (frames.expected_q.size() != 0);
    endtask

    // Mostly complete frames; the rest are abandoned frames and stray payload words.
    task automatic random_frame();
        int pick;
        int len;
        int count;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
            send_start(8'($urandom), 8'($urandom), 16'(len));
            repeat (len) send_payload(8'($urandom));
        end
        else if (pick < 85)
        begin
            len   = $urandom_range(16'hFFFF);
            count = $urandom_range(4);
            if (count >= len)
                count = (len > 0) ? len - 1 : 0;
            send_start(8'($urandom), 8'($urandom), 16'(len));
            repeat (count) send_payload(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
        end
    endtask

    initial
    begin
        logic [7:0] first_sync[4];
        logic [7:0] second_sync[4];
        int         target;
        first_sync[0]  = 8'h00;
        second_sync[0] = 8'hFF;
        first_sync[1]  = 8'hFF;
        second_sync[1] = 8'h00;
        first_sync[2]  = 8'($urandom_range(1, 254));
        second_sync[2] = 8'($urandom_range(1, 254));
        first_sync[3]  = SYNC_FIRST_RST;
        second_sync[3] = SYNC_SECOND_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset sync bytes.
        send_payload(8'hFF);
        send_start(8'hFF, 8'h00, 16'h0000);
        send_start(8'h00, 8'hFF, 16'd3);
        send_payload(8'hFF);
        send_payload(8'h00);
        send_payload(8'h5A);
        send_payload(8'hA5);
        send_start(8'h12, 8'h34, 16'hFFFF);
        send_payload(8'h01);
        send_payload(8'hFE);
        send_start(8'hAA, 8'h55, 16'd1);
        send_payload(8'h80);
        drain();
        write_reg(CFG_IDX_BEYOND, 8'h3C);
        cfg_valid <= 1'b0;
        send_start(8'h3C, 8'hC3, 16'h0100);
        send_start(8'h01, 8'h02, 16'd2);
        send_payload(8'h7F);
        send_payload(8'hC0);

        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_reg(CFG_SYNC_FIRST, first_sync[p]);
            write_reg(CFG_SYNC_SECOND, second_sync[p]);
            cfg_valid <= 1'b0;
            calm   = (p == 2);
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
                random_frame();
        end
        drain();
        calm = 1'b0;
        repeat (20) @(posedge clk);

        $display("Sent %0d input words (%0d frame starts, %0d stray payload words) under five",
                 words_sent, frames.starts_seen, frames.strays_seen);
        $display("sync byte settings; checked %0d output words, %0d mismatches.",
                 frames.words_checked, frames.errors);
        if (frames.errors == 0 && frames.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire
